### rtl/core/eri_pkg.sv
// ----------------------------------------------------------------------------
// eri_pkg
// Shared widths, fixed-point constants, register indexes and the two curve
// tables (sine and versine over a quarter turn) of the rotation interpolator.
// ----------------------------------------------------------------------------
package eri_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TAB_BITS   = 8;
    localparam int TAB_LEN    = (1 << TAB_BITS) + 1;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int PHASE_W    = FRAC_BITS + 2;
    localparam int TIME_W     = 24;
    localparam int DIV_NUM_W  = TIME_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int MUL_W      = FRAC_W;
    localparam int MUL_CNT_W  = $clog2(MUL_W + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [FRAC_W-1:0]  ONE       = FRAC_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_IN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_OUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z    = 3'd5;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic [FRAC_W-1:0] t_tab [0:TAB_LEN-1];

    // restoring long division, only used while building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // taylor series in Q30, evaluated at elaboration only
    function automatic t_tab build_tab(input logic vers);
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        int          n;
        logic        neg;
        for (int k = 0; k < TAB_LEN; k++) begin
            x    = udiv64((64'(k) * 64'd157) << 30, 64'd100 << TAB_BITS);
            x2   = (x * x) >> 30;
            term = vers ? (x2 >> 1) : x;
            n    = vers ? 2 : 1;
            sum  = 0;
            neg  = 1'b0;
            for (int i = 0; i < 7; i++) begin
                if (n <= 13) begin
                    sum  = neg ? sum - longint'(term) : sum + longint'(term);
                    term = udiv64((term * x2) >> 30, 64'((n + 1) * (n + 2)));
                    n    = n + 2;
                    neg  = !neg;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            tab[k] = (r > 64'(ONE)) ? ONE : r[FRAC_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab SIN_TAB  = build_tab(1'b0);
    localparam t_tab VERS_TAB = build_tab(1'b1);

endpackage

### rtl/core/eri_in_if.sv
// ----------------------------------------------------------------------------
// eri_in_if
// Input item channel: start or tick beat with elapsed time and start angles.
// ----------------------------------------------------------------------------
interface eri_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [15:0]        delta_us;
    logic signed [15:0] start_angle_x;
    logic signed [15:0] start_angle_y;
    logic signed [15:0] start_angle_z;

    modport source (output valid, mode, delta_us, start_angle_x, start_angle_y,
                    start_angle_z, input ready);
    modport sink (input valid, mode, delta_us, start_angle_x, start_angle_y,
                  start_angle_z, output ready);
endinterface

### rtl/core/eri_out_if.sv
// ----------------------------------------------------------------------------
// eri_out_if
// Result channel: interpolated angles, progress and done flag.
// ----------------------------------------------------------------------------
interface eri_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic [16:0]        progress;
    logic               done_res;

    modport source (output valid, angle_x, angle_y, angle_z, progress, done_res,
                    input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, progress, done_res,
                  output ready);
endinterface

### rtl/core/eri_cfg_if.sv
// ----------------------------------------------------------------------------
// eri_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface eri_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/eri_div_serial.sv
// ----------------------------------------------------------------------------
// eri_div_serial
// Restoring divider, one quotient bit per cycle, DIV_NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module eri_div_serial
    import eri_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [TIME_W-1:0]    i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_den;
    logic [TIME_W:0]      w_trial;
    logic                 w_qbit;

    // trial subtract of the next dividend bit
    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_qbit ? TIME_W'(w_trial - {1'b0, r_den}) : w_trial[TIME_W-1:0];
                r_num <= {r_num[DIV_NUM_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

### rtl/core/eri_mul_serial.sv
// ----------------------------------------------------------------------------
// eri_mul_serial
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module eri_mul_serial
    import eri_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic               o_done,
    output logic [2*MUL_W-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [2*MUL_W-1:0]   r_acc;
    logic [2*MUL_W-1:0]   r_mcand;
    logic [MUL_W-1:0]     r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= {{MUL_W{1'b0}}, i_a};
                r_mplier <= i_b;
            end else if (r_busy) begin
                // add the shifted multiplicand when the low bit is set
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[2*MUL_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[MUL_W-1:1]};
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/core/eased_rotation_interpolator.sv
// ----------------------------------------------------------------------------
// eased_rotation_interpolator
// Eased three-axis rotation interpolator with sine ease-in/ease-out segments.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg writes duration, ease-in, ease-out and the three end angles by
//   index, by the user only while the block is idle (not checked); always ready.
//   i_in takes one beat at a time: mode start latches the start angles and
//   computes the ease ratios, mode tick advances the phase by delta/duration.
//   o_out gives one beat per input beat: three angles, progress, done flag.
// Arithmetic:
//   every quotient comes from a 40-step bit-serial divider and every
//   product from a 17-step shift-add multiplier, both shared.
//   a start beat takes two divides and three lerp products, a tick one
//   to two divides and up to five products; a zero duration needs no
//   divide. one beat is in work at a time.
// Reset: registers take their reset values and the phase, ratios and weight
//   clear; the block is ready for input in the first cycle after reset.
// Stall: a finished result waits in the output register; the next beat is
//   already accepted and worked on, and its result holds until that is taken.
// ----------------------------------------------------------------------------
module eased_rotation_interpolator
    import eri_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    eri_cfg_if.sink  i_cfg,
    eri_in_if.sink   i_in,
    eri_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATIO_IN,
        S_RATIO_OUT,
        S_STEP,
        S_SEG,
        S_LOOK,
        S_INTERP,
        S_SCALE_ISSUE,
        S_SCALE,
        S_LERP_ISSUE,
        S_LERP,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [TIME_W-1:0]  r_dur;
    logic [TIME_W-1:0]  r_ein;
    logic [TIME_W-1:0]  r_eout;
    logic signed [15:0] r_end [0:2];

    // interpolation state
    logic signed [15:0] r_origin [0:2];
    logic [PHASE_W-1:0] r_phase;
    logic [FRAC_W-1:0]  r_in_ratio;
    logic [FRAC_W-1:0]  r_out_ratio;
    logic [FRAC_W-1:0]  r_out_begin;
    logic [FRAC_W-1:0]  r_weight;
    logic [FRAC_W-1:0]  r_t;
    logic [FRAC_W-1:0]  r_lo;
    logic [FRAC_W-1:0]  r_tl;
    logic               r_seg_out;
    logic [1:0]         r_axis;
    logic               r_mul_neg;
    logic signed [15:0] r_res [0:2];

    // shared units
    logic                 r_div_go;
    logic                 n_div_go;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [TIME_W-1:0]    r_div_den;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_div_quot;
    logic                 r_mul_go;
    logic                 n_mul_go;
    logic [MUL_W-1:0]     r_mul_a;
    logic [MUL_W-1:0]     r_mul_b;
    logic                 w_mul_done;
    logic [2*MUL_W-1:0]   w_mul_prod;

    // output register
    logic               r_out_valid;
    logic               n_out_valid;
    logic signed [15:0] r_out_angle [0:2];
    logic [FRAC_W-1:0]  r_out_progress;
    logic               r_out_done;

    eri_div_serial u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    eri_mul_serial u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // quotient saturation and phase update
    logic [FRAC_W-1:0]  w_q_one;
    logic [PHASE_W-1:0] w_q_step;
    logic [PHASE_W:0]   w_sum;
    logic [PHASE_W-1:0] w_nphase;
    logic               w_in_seg;
    logic               w_out_seg;
    logic [PHASE_W-1:0] w_out_off;

    assign w_q_one   = (w_div_quot > DIV_NUM_W'(ONE)) ? ONE : w_div_quot[FRAC_W-1:0];
    assign w_q_step  = (w_div_quot > DIV_NUM_W'(PHASE_MAX)) ? PHASE_MAX
                                                            : w_div_quot[PHASE_W-1:0];
    assign w_sum     = {1'b0, r_phase} + {1'b0, w_q_step};
    assign w_nphase  = (w_sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : w_sum[PHASE_W-1:0];
    assign w_in_seg  = (r_ein != '0) && (w_nphase <= {1'b0, r_in_ratio});
    assign w_out_seg = (r_eout != '0) && (w_nphase >= {1'b0, r_out_begin});
    assign w_out_off = w_nphase - {1'b0, r_out_begin};

    // curve table lookup
    logic [8:0]        w_idx;
    logic [8:0]        w_idx_n;
    logic [FRAC_W-1:0] w_tab_lo;
    logic [FRAC_W-1:0] w_tab_hi;
    logic [FRAC_W-1:0] w_tab_end;

    assign w_idx     = r_t[FRAC_W-1:FRAC_BITS-TAB_BITS];
    assign w_idx_n   = w_idx + 1'b1;
    assign w_tab_lo  = r_seg_out ? SIN_TAB[w_idx] : VERS_TAB[w_idx];
    assign w_tab_hi  = r_seg_out ? SIN_TAB[w_idx_n] : VERS_TAB[w_idx_n];
    assign w_tab_end = r_seg_out ? SIN_TAB[TAB_LEN-1] : VERS_TAB[TAB_LEN-1];

    // ratio scaling of the curve value
    logic [FRAC_W:0]   w_scaled;
    logic [FRAC_W:0]   w_seg_w;
    logic [FRAC_W-1:0] w_seg_cap;

    assign w_scaled  = w_mul_prod[2*MUL_W-1:FRAC_BITS];
    assign w_seg_w   = r_seg_out ? w_scaled + {1'b0, r_out_begin} : w_scaled;
    assign w_seg_cap = (w_seg_w > {1'b0, ONE}) ? ONE : w_seg_w[FRAC_W-1:0];

    // lerp difference and rounded result
    logic signed [16:0]      w_diff;
    logic [16:0]             w_dmag;
    logic signed [2*MUL_W+1:0] w_lerp_p;

    assign w_diff   = 17'(r_end[r_axis]) - 17'(r_origin[r_axis]);
    assign w_dmag   = w_diff[16] ? 17'(-w_diff) : w_diff;
    assign w_lerp_p = (r_mul_neg ? -$signed({2'b00, w_mul_prod})
                                 : $signed({2'b00, w_mul_prod}))
                      + (2*MUL_W+2)'(ONE >> 1);

    // start pulses for the shared units
    assign n_div_go = ((r_state == S_IDLE) && i_in.valid && (r_dur != '0))
                   || ((r_state == S_RATIO_IN) && w_div_done)
                   || ((r_state == S_STEP) && w_div_done
                       && ((w_in_seg && (r_in_ratio != '0))
                           || (!w_in_seg && w_out_seg && (r_out_ratio != '0))));
    assign n_mul_go = ((r_state == S_LOOK) && !r_t[FRAC_W-1] && (w_tab_hi > w_tab_lo))
                   || (r_state == S_SCALE_ISSUE)
                   || (r_state == S_LERP_ISSUE);

    // output beat loaded, or held until taken
    assign n_out_valid = ((r_state == S_EMIT) && (!r_out_valid || o_out.ready))
                      || (r_out_valid && !o_out.ready);

    // configuration port never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dur       <= TIME_W'(1000000);
            r_ein       <= '0;
            r_eout      <= '0;
            r_end[0]    <= '0;
            r_end[1]    <= '0;
            r_end[2]    <= '0;
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_phase     <= '0;
            r_in_ratio  <= '0;
            r_out_ratio <= '0;
            r_out_begin <= ONE;
            r_weight    <= '0;
            r_div_go    <= 1'b0;
            r_mul_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go    <= n_div_go;
            r_mul_go    <= n_mul_go;
            r_out_valid <= n_out_valid;

            // register writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_DURATION: r_dur    <= i_cfg.data;
                    CFG_EASE_IN:  r_ein    <= i_cfg.data;
                    CFG_EASE_OUT: r_eout   <= i_cfg.data;
                    CFG_END_X:    r_end[0] <= i_cfg.data[15:0];
                    CFG_END_Y:    r_end[1] <= i_cfg.data[15:0];
                    CFG_END_Z:    r_end[2] <= i_cfg.data[15:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    r_axis <= '0;
                    if (i_in.valid) begin
                        if (i_in.mode == MODE_START) begin
                            r_origin[0] <= i_in.start_angle_x;
                            r_origin[1] <= i_in.start_angle_y;
                            r_origin[2] <= i_in.start_angle_z;
                            r_phase     <= '0;
                            r_weight    <= '0;
                            if (r_dur == '0) begin
                                r_in_ratio  <= (r_ein != '0) ? ONE : '0;
                                r_out_ratio <= (r_eout != '0) ? ONE : '0;
                                r_out_begin <= (r_eout != '0) ? '0 : ONE;
                                r_state     <= S_LERP_ISSUE;
                            end else begin
                                r_div_num <= {r_ein, FRAC_BITS'(0)};
                                r_div_den <= r_dur;
                                r_state   <= S_RATIO_IN;
                            end
                        end else begin
                            if (r_dur == '0) begin
                                r_phase  <= PHASE_W'(ONE);
                                r_weight <= ONE;
                                r_state  <= S_LERP_ISSUE;
                            end else begin
                                r_div_num <= DIV_NUM_W'({i_in.delta_us, FRAC_BITS'(0)});
                                r_div_den <= r_dur;
                                r_state   <= S_STEP;
                            end
                        end
                    end
                end
                S_RATIO_IN: begin
                    if (w_div_done) begin
                        r_in_ratio <= w_q_one;
                        r_div_num  <= {r_eout, FRAC_BITS'(0)};
                        r_div_den  <= r_dur;
                        r_state    <= S_RATIO_OUT;
                    end
                end
                S_RATIO_OUT: begin
                    if (w_div_done) begin
                        r_out_ratio <= w_q_one;
                        r_out_begin <= ONE - w_q_one;
                        r_state     <= S_LERP_ISSUE;
                    end
                end
                S_STEP: begin
                    if (w_div_done) begin
                        r_phase <= w_nphase;
                        if (w_in_seg) begin
                            r_seg_out <= 1'b0;
                            if (r_in_ratio == '0) begin
                                r_t     <= (w_nphase != '0) ? ONE : '0;
                                r_state <= S_LOOK;
                            end else begin
                                r_div_num <= DIV_NUM_W'({w_nphase, FRAC_BITS'(0)});
                                r_div_den <= TIME_W'(r_in_ratio);
                                r_state   <= S_SEG;
                            end
                        end else if (w_out_seg) begin
                            r_seg_out <= 1'b1;
                            if (r_out_ratio == '0) begin
                                r_t     <= (w_out_off != '0) ? ONE : '0;
                                r_state <= S_LOOK;
                            end else begin
                                r_div_num <= DIV_NUM_W'({w_out_off, FRAC_BITS'(0)});
                                r_div_den <= TIME_W'(r_out_ratio);
                                r_state   <= S_SEG;
                            end
                        end else begin
                            r_weight <= (w_nphase > PHASE_W'(ONE)) ? ONE
                                                                   : w_nphase[FRAC_W-1:0];
                            r_state  <= S_LERP_ISSUE;
                        end
                    end
                end
                S_SEG: begin
                    if (w_div_done) begin
                        r_t     <= w_q_one;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // end of table, flat step or linear blend between entries
                    if (r_t[FRAC_W-1]) begin
                        r_tl    <= w_tab_end;
                        r_state <= S_SCALE_ISSUE;
                    end else if (w_tab_hi <= w_tab_lo) begin
                        r_tl    <= w_tab_lo;
                        r_state <= S_SCALE_ISSUE;
                    end else begin
                        r_lo     <= w_tab_lo;
                        r_mul_a  <= w_tab_hi - w_tab_lo;
                        r_mul_b  <= {1'b0, r_t[FRAC_BITS-TAB_BITS-1:0], TAB_BITS'(0)};
                        r_state  <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    if (w_mul_done) begin
                        r_tl    <= r_lo + w_mul_prod[FRAC_BITS+FRAC_W-1:FRAC_BITS];
                        r_state <= S_SCALE_ISSUE;
                    end
                end
                S_SCALE_ISSUE: begin
                    r_mul_a  <= r_tl;
                    r_mul_b  <= r_seg_out ? r_out_ratio : r_in_ratio;
                    r_state  <= S_SCALE;
                end
                S_SCALE: begin
                    if (w_mul_done) begin
                        r_weight <= w_seg_cap;
                        r_state  <= S_LERP_ISSUE;
                    end
                end
                S_LERP_ISSUE: begin
                    r_mul_a   <= w_dmag;
                    r_mul_b   <= r_weight;
                    r_mul_neg <= w_diff[16];
                    r_state   <= S_LERP;
                end
                S_LERP: begin
                    if (w_mul_done) begin
                        r_res[r_axis] <= r_origin[r_axis] + w_lerp_p[FRAC_BITS+15:FRAC_BITS];
                        if (r_axis == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_LERP_ISSUE;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_angle[0] <= r_res[0];
                        r_out_angle[1] <= r_res[1];
                        r_out_angle[2] <= r_res[2];
                        r_out_progress <= r_weight;
                        r_out_done     <= (r_weight >= ONE);
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.angle_x  = r_out_angle[0];
    assign o_out.angle_y  = r_out_angle[1];
    assign o_out.angle_z  = r_out_angle[2];
    assign o_out.progress = r_out_progress;
    assign o_out.done_res = r_out_done;

    // an accepted beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted twice in a row");

    // the weight never leaves [0, one]
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= ONE)
        else $error("weight above one");

    // done flag agrees with the progress it is sent with
    a_done_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.done_res == (o_out.progress == ONE)))
        else $error("done flag and progress disagree");

endmodule
